// ===== src/csgm_pkg.sv =====
// ---------------------------------------------------------------------------
// csgm_pkg: shared types and constants for the channel smoothing mixer
// Sequencer states, register indexes, fixed-point constants and the control
// group that drives the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package csgm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHAR,
        ST_MUL_A,
        ST_MUL_B,
        ST_SMOOTH,
        ST_G0_MUL,
        ST_G0_ADD,
        ST_G_MUL,
        ST_G_ADD,
        ST_RD_ADDR,
        ST_RD_DATA
    } state_t;

    typedef struct packed {
        logic enable;
        logic accumulate;
    } mac_ctrl_t;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF3     = 3'd4;

    localparam logic [4:0]  CHUNK_LEN_RESET = 5'd1;
    localparam logic [33:0] COEF_RESET      = 34'd8590000128;
    localparam logic [16:0] ONE_Q16         = 17'd65536;
    localparam logic signed [48:0] CLAMP_Q16 = 49'sd4294901760;
    localparam logic [7:0]  CHAR_ZERO       = 8'h30;
    localparam logic [7:0]  CHAR_NINE       = 8'h39;
    localparam logic [15:0] RESULT_MAX      = 16'hFFFF;

endpackage
`default_nettype wire

// ===== src/csgm_mac.sv =====
// ---------------------------------------------------------------------------
// csgm_mac: shared multiply-accumulate unit
// Multiplies an unsigned Q1.16 coefficient by a signed Q.16 operand, adds the
// product into an accumulator, and presents the floored, clamped Q.16 result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csgm_mac (
    input  wire logic                clk,
    input  wire csgm_pkg::mac_ctrl_t ctrl,
    input  wire logic [16:0]         coef,
    input  wire logic signed [48:0]  operand,
    output logic signed [48:0]       result
);
    import csgm_pkg::*;

    logic signed [65:0] acc_reg;
    logic signed [65:0] acc_next;
    logic signed [65:0] product;
    logic signed [65:0] shifted;

    always_comb
    begin
        product  = 66'($signed({1'b0, coef})) * 66'(operand);
        acc_next = (ctrl.accumulate ? acc_reg : 66'sd0) + product;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.enable)
        begin
            acc_reg <= acc_next;
        end
    end

    // The arithmetic shift floors towards minus infinity.
    always_comb
    begin
        shifted = acc_reg >>> 16;
        if (shifted > 66'(CLAMP_Q16))
        begin
            result = CLAMP_Q16;
        end
        else
        begin
            result = shifted[48:0];
        end
    end

endmodule
`default_nettype wire

// ===== src/channel_smooth_gain_mixer.sv =====
// A character without a finished sample passes ST_IDLE and ST_CHAR only; a sample
// goes on through ST_MUL_A, ST_MUL_B, ST_SMOOTH, ST_G_MUL and ST_G_ADD, with ST_G0_MUL
// and ST_G0_ADD between on a channel's second sample; a read passes ST_RD_ADDR and
// ST_RD_DATA, waiting there for the output register to drain. One transaction is in
// flight at a time: the input is ready only in ST_IDLE, and the MAC unit is shared.
// Reset is asynchronous and clears all control state at once; no clear pass.
// ---------------------------------------------------------------------------
// channel_smooth_gain_mixer: per-channel smoothing, gain and summing
// Parses decimal samples from tagged characters, smooths and scales them and
// accumulates them into a per-index sum memory that reads can query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module channel_smooth_gain_mixer #(
    parameter int unsigned CHANNELS     = 4,
    parameter int unsigned SAMPLE_DEPTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [1:0] channel, [9:2] char_byte, [19:10] read_index, [23:20] zero
    input  wire logic [23:0]                        s_axis_tdata,
    // [0] action
    input  wire logic                               s_axis_tuser,
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [33:0] mixed_value, [44:34] samples_in_use, [45] overflow_seen, [47:46] zero
    output logic [47:0]                             m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [csgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [33:0]                        cfg_data
);
    import csgm_pkg::*;

    localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned AW  = $clog2(SAMPLE_DEPTH);
    localparam int unsigned CW  = $clog2(SAMPLE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [1:0]  chan_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [9:0]  idx_reg;

    logic [4:0]  chunk_len_reg;
    logic [33:0] coef_reg [4];

    logic [4:0]         pos_reg   [CHANNELS];
    logic [31:0]        dval_reg  [CHANNELS];
    logic               seen_reg  [CHANNELS];
    logic signed [48:0] prev_reg  [CHANNELS];
    logic [CW-1:0]      cnt_reg   [CHANNELS];
    logic               ended_reg [CHANNELS];

    logic [CW-1:0]      longest_reg;
    logic               dropped_reg;
    logic signed [48:0] xq_reg;
    logic signed [48:0] f_reg;
    logic [16:0]        alpha_reg;
    logic [16:0]        beta_reg;
    logic [CW-1:0]      n_reg;

    logic               out_valid_reg;
    logic [47:0]        out_data_reg;

    logic signed [51:0] mem [SAMPLE_DEPTH];
    logic signed [51:0] mem_rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic signed [51:0] wr_data;

    mac_ctrl_t          mac_ctrl;
    logic [16:0]        mac_coef;
    logic signed [48:0] mac_operand;
    logic signed [48:0] mac_result;

    logic [CHW-1:0]     ci;
    logic               ch_ok;
    logic               is_digit;
    logic [31:0]        dv_new;
    logic               seen_new;
    logic [5:0]         pos_inc;
    logic               finish;
    logic [16:0]        a_cur;
    logic [16:0]        b_cur;
    logic               take;
    logic [CW-1:0]      cnt_cur;
    logic signed [48:0] xq_new;
    logic               out_load;
    logic               out_free;
    logic               rd_ok;
    logic signed [51:0] rd_sum;
    logic signed [51:0] rd_round;
    logic [33:0]        mixed;
    logic signed [51:0] old_sum;

    // ---------------- character decode for the latched channel ----------------
    always_comb
    begin
        ci       = chan_reg[CHW-1:0];
        ch_ok    = (32'(chan_reg) < CHANNELS) && !ended_reg[ci];
        is_digit = byte_reg inside {[CHAR_ZERO:CHAR_NINE]};
        dv_new   = is_digit ? (dval_reg[ci] << 3) + (dval_reg[ci] << 1)
                              + 32'(byte_reg - CHAR_ZERO)
                            : dval_reg[ci];
        seen_new = seen_reg[ci] || is_digit;
        pos_inc  = 6'(pos_reg[ci]) + 6'd1;
        // A chunk length of zero closes every chunk after one character.
        finish   = last_reg || (pos_inc >= {1'b0, chunk_len_reg});
        a_cur    = coef_reg[chan_reg][33:17];
        b_cur    = coef_reg[chan_reg][16:0];
        take     = finish && seen_new && (a_cur <= ONE_Q16) && (b_cur <= ONE_Q16);
        cnt_cur  = cnt_reg[ci];
        xq_new   = {dv_new[31], dv_new, 16'h0000};
    end

    // ---------------- read result ----------------
    // Entries at or above the longest count have never been written and read as zero.
    always_comb
    begin
        rd_ok    = (32'(idx_reg) < SAMPLE_DEPTH) && (32'(idx_reg) < 32'(longest_reg));
        rd_sum   = rd_ok ? mem_rdata_reg : 52'sd0;
        rd_round = (rd_sum + 52'sd65535) >>> 16;
        if (rd_sum > 52'(CLAMP_Q16))
        begin
            mixed = 34'(RESULT_MAX);
        end
        else
        begin
            mixed = rd_round[33:0];
        end
        out_free = !out_valid_reg || m_axis_tready;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = s_axis_tuser ? ST_RD_ADDR : ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (ch_ok && take && (cnt_cur != '0) && (32'(cnt_cur) < SAMPLE_DEPTH))
                begin
                    state_next = ST_MUL_A;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_A:   state_next = ST_MUL_B;
            ST_MUL_B:   state_next = ST_SMOOTH;
            ST_SMOOTH:  state_next = (n_reg == CW'(1)) ? ST_G0_MUL : ST_G_MUL;
            ST_G0_MUL:  state_next = ST_G0_ADD;
            ST_G0_ADD:  state_next = ST_G_MUL;
            ST_G_MUL:   state_next = ST_G_ADD;
            ST_G_ADD:   state_next = ST_IDLE;
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        mac_ctrl      = '0;
        mac_coef      = alpha_reg;
        mac_operand   = xq_reg;
        rd_addr       = AW'(32'(idx_reg));
        mem_we        = 1'b0;
        wr_addr       = n_reg[AW-1:0];
        old_sum       = (n_reg < longest_reg) ? mem_rdata_reg : 52'sd0;
        wr_data       = old_sum + 52'(mac_result);
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:    s_axis_tready = 1'b1;
            ST_MUL_A:   mac_ctrl = '{enable: 1'b1, accumulate: 1'b0};
            ST_MUL_B:
            begin
                mac_ctrl    = '{enable: 1'b1, accumulate: 1'b1};
                mac_coef    = ONE_Q16 - alpha_reg;
                mac_operand = prev_reg[ci];
            end
            ST_G0_MUL:
            begin
                mac_ctrl    = '{enable: 1'b1, accumulate: 1'b0};
                mac_coef    = beta_reg;
                mac_operand = prev_reg[ci];
                rd_addr     = '0;
            end
            ST_G0_ADD:
            begin
                mem_we  = 1'b1;
                wr_addr = '0;
                old_sum = (longest_reg != '0) ? mem_rdata_reg : 52'sd0;
                wr_data = old_sum + 52'(mac_result);
            end
            ST_G_MUL:
            begin
                mac_ctrl    = '{enable: 1'b1, accumulate: 1'b0};
                mac_coef    = beta_reg;
                mac_operand = f_reg;
                rd_addr     = n_reg[AW-1:0];
            end
            ST_G_ADD:   mem_we = 1'b1;
            ST_RD_DATA: out_load = out_free;
            default:    s_axis_tready = 1'b0;
        endcase
    end

    csgm_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .result  (mac_result)
    );

    // ---------------- sum memory ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_rdata_reg <= mem[rd_addr];
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            chan_reg <= s_axis_tdata[1:0];
            byte_reg <= s_axis_tdata[9:2];
            idx_reg  <= s_axis_tdata[19:10];
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_CHAR)
        begin
            xq_reg    <= xq_new;
            alpha_reg <= a_cur;
            beta_reg  <= b_cur;
            n_reg     <= cnt_cur;
        end
        if (state_reg == ST_SMOOTH)
        begin
            f_reg <= mac_result;
        end
        if (out_load)
        begin
            out_data_reg <= {2'b00, dropped_reg, 11'(longest_reg), mixed};
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunk_len_reg <= CHUNK_LEN_RESET;
            for (int i = 0; i < 4; i++)
            begin
                coef_reg[i] <= COEF_RESET;
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]   <= '0;
                dval_reg[i]  <= '0;
                seen_reg[i]  <= 1'b0;
                prev_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
                ended_reg[i] <= 1'b0;
            end
            longest_reg   <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHUNK_LEN: chunk_len_reg <= cfg_data[4:0];
                    REG_COEF0:     coef_reg[0]   <= cfg_data;
                    REG_COEF1:     coef_reg[1]   <= cfg_data;
                    REG_COEF2:     coef_reg[2]   <= cfg_data;
                    REG_COEF3:     coef_reg[3]   <= cfg_data;
                    default:       chunk_len_reg <= chunk_len_reg;
                endcase
            end

            if ((state_reg == ST_CHAR) && ch_ok)
            begin
                if (finish)
                begin
                    pos_reg[ci]  <= '0;
                    dval_reg[ci] <= '0;
                    seen_reg[ci] <= 1'b0;
                end
                else
                begin
                    pos_reg[ci]  <= pos_inc[4:0];
                    dval_reg[ci] <= dv_new;
                    seen_reg[ci] <= seen_new;
                end
                if (last_reg)
                begin
                    ended_reg[ci] <= 1'b1;
                end
                if (take)
                begin
                    if (32'(cnt_cur) >= SAMPLE_DEPTH)
                    begin
                        dropped_reg <= 1'b1;
                    end
                    else if (cnt_cur == '0)
                    begin
                        // The first sample is held until the second one arrives.
                        prev_reg[ci] <= xq_new;
                        cnt_reg[ci]  <= CW'(1);
                    end
                end
            end

            if (state_reg == ST_G_ADD)
            begin
                prev_reg[ci] <= f_reg;
                cnt_reg[ci]  <= n_reg + CW'(1);
                if ((n_reg + CW'(1)) > longest_reg)
                begin
                    longest_reg <= n_reg + CW'(1);
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== src/csgm_checker.sv =====
// ---------------------------------------------------------------------------
// csgm_checker: port-level checks for the channel smoothing mixer
// Watches the input and result stream ports and is bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csgm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Each accepted item takes the sequencer out of ST_IDLE, so inputs are never accepted back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // A new result only appears while an item is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

    // The mixed value never exceeds the clamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[33:0]) <= 34'sd65535)
        else $error("mixed value above clamp");

endmodule

bind channel_smooth_gain_mixer csgm_checker u_csgm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/csgm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csgm_scoreboard: result predictor and scoreboard for the smoothing mixer
// Watches the configuration port and both stream channels, keeps its own
// copy of the per-channel parsing, smoothing and sum memory state, and
// compares every read result against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module csgm_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [csgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [33:0] cfg_data,
    output int          failures,
    output int          pending,
    output int          reads_checked
);
    import csgm_pkg::*;

    localparam int DEPTH = 1024;
    localparam longint SAT_Q16 = 64'sd4294901760;

    // Packed from the top bit down, so mixed sits in the lowest bits.
    typedef struct packed {
        logic        overflow;
        logic [10:0] in_use;
        logic [33:0] mixed;
    } mix_result_t;

    mix_result_t sum_reads_q[$];

    logic [4:0]  chunk_len;
    logic [33:0] coef [4];
    logic [4:0]  pos [4];
    logic [31:0] digits [4];
    bit          got_digit [4];
    longint      prev_smooth [4];
    int unsigned sample_count [4];
    bit          ended [4];
    longint      sums [DEPTH];
    int unsigned longest;
    bit          dropped;

    function automatic longint floor_q16(logic [63:0] t);
        return $signed(t) >>> 16;
    endfunction

    function automatic longint sat_top(longint v);
        return (v > SAT_Q16) ? SAT_Q16 : v;
    endfunction

    function automatic longint ema(longint xq, longint prev, int unsigned a);
        logic [63:0] t;
        t = 64'(a) * 64'(xq) + 64'(65536 - a) * 64'(prev);
        return sat_top(floor_q16(t));
    endfunction

    function automatic longint gained(longint f, int unsigned b);
        logic [63:0] t;
        t = 64'(b) * 64'(f);
        return sat_top(floor_q16(t));
    endfunction

    task close_chunk(input int c);
        int unsigned a, b, n;
        longint xq, f;
        bit had;
        a = 32'(coef[c][33:17]);
        b = 32'(coef[c][16:0]);
        n = sample_count[c];
        had = got_digit[c];
        xq = longint'($signed(digits[c])) * 65536;
        pos[c] = '0;
        digits[c] = '0;
        got_digit[c] = 1'b0;
        if (!had || a > 65536 || b > 65536)
            return;
        if (n >= DEPTH)
        begin
            dropped = 1'b1;
            return;
        end
        if (n == 0)
        begin
            prev_smooth[c] = xq;
            sample_count[c] = 1;
            return;
        end
        f = ema(xq, prev_smooth[c], a);
        // The first sample is only summed once a second one exists.
        if (n == 1)
            sums[0] += gained(prev_smooth[c], b);
        sums[n] += gained(f, b);
        prev_smooth[c] = f;
        n++;
        sample_count[c] = n;
        if (n > longest)
            longest = n;
    endtask

    always @(posedge clk)
    begin
        longint s, r;
        mix_result_t exp_r, got_r;
        int c;
        logic [7:0] ch;
        if (!rst_n)
        begin
            chunk_len = CHUNK_LEN_RESET;
            for (int i = 0; i < 4; i++)
            begin
                coef[i] = COEF_RESET;
                pos[i] = '0;
                digits[i] = '0;
                got_digit[i] = 1'b0;
                prev_smooth[i] = 0;
                sample_count[i] = 0;
                ended[i] = 1'b0;
            end
            for (int i = 0; i < DEPTH; i++)
                sums[i] = 0;
            longest = 0;
            dropped = 1'b0;
            failures <= 0;
            reads_checked <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CHUNK_LEN)
                    chunk_len = cfg_data[4:0];
                else if (cfg_index >= REG_COEF0 && cfg_index <= REG_COEF3)
                    coef[cfg_index - REG_COEF0] = cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser)
                begin
                    s = sums[s_axis_tdata[19:10]];
                    if (s > SAT_Q16)
                        r = 65535;
                    else if (s >= 0)
                        r = (s + 65535) / 65536;
                    else
                        r = -((-s) / 65536);
                    exp_r.mixed = r[33:0];
                    exp_r.in_use = longest[10:0];
                    exp_r.overflow = dropped;
                    sum_reads_q.push_back(exp_r);
                end
                else
                begin
                    c = 32'(s_axis_tdata[1:0]);
                    ch = s_axis_tdata[9:2];
                    if (!ended[c])
                    begin
                        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                        begin
                            digits[c] = digits[c] * 32'd10 + 32'(ch - CHAR_ZERO);
                            got_digit[c] = 1'b1;
                        end
                        pos[c]++;
                        if (s_axis_tlast || pos[c] >= chunk_len)
                            close_chunk(c);
                        if (s_axis_tlast)
                            ended[c] = 1'b1;
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r = m_axis_tdata[45:0];
                if (sum_reads_q.size() == 0)
                begin
                    $display("%t: unexpected result %h", $time, got_r);
                    failures <= failures + 1;
                end
                else
                begin
                    exp_r = sum_reads_q.pop_front();
                    reads_checked <= reads_checked + 1;
                    if (got_r.mixed !== exp_r.mixed
                        || got_r.in_use !== exp_r.in_use
                        || got_r.overflow !== exp_r.overflow)
                    begin
                        $display("%t: mixed_value exp %0d got %0d, in_use exp %0d got %0d,",
                                 $time, $signed(exp_r.mixed), $signed(got_r.mixed),
                                 exp_r.in_use, got_r.in_use);
                        $display("%t:   overflow exp %0d got %0d", $time,
                                 exp_r.overflow, got_r.overflow);
                        failures <= failures + 1;
                    end
                end
            end
            pending <= sum_reads_q.size();
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for channel_smooth_gain_mixer
// Runs a directed opening and then random character and read streams over
// several chunk lengths and coefficient settings, including a pass that
// fills the sum memory, with random gaps on both stream channels.
// ---------------------------------------------------------------------------
module tb;
    import csgm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CHUNK_LEN;
    logic [33:0] cfg_data = '0;

    int failures, pending, reads_checked;
    int items_sent = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int stall_left = 0;

    channel_smooth_gain_mixer uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    csgm_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending), .reads_checked(reads_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && r < 8)
        begin
            stall_left <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else if (!calm && r < 10)
        begin
            stall_left <= $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [7:0] digit_char();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [33:0] rand_coef(bit allow_bad);
        logic [16:0] a, b;
        a = (allow_bad && $urandom_range(0, 9) == 0) ? 17'($urandom_range(65537, 131071))
                                                    : 17'($urandom_range(0, 65536));
        b = (allow_bad && $urandom_range(0, 9) == 0) ? 17'($urandom_range(65537, 131071))
                                                    : 17'($urandom_range(0, 65536));
        return {a, b};
    endfunction

    task send(input bit rd, input logic [1:0] chn, input logic [7:0] ch,
              input bit eoc, input logic [9:0] idx);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rd;
        s_axis_tlast <= eoc;
        s_axis_tdata <= {4'b0, idx, ch, chn};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        g = $urandom_range(0, 99);
        if (!calm && g >= 60)
        begin
            s_axis_tvalid <= 1'b0;
            if (g < 92)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else
                repeat ($urandom_range(10, 30)) @(posedge clk);
        end
    endtask

    task send_random(input int chan_bias, input int eoc_pct, input int digit_pct);
        logic [1:0] chn;
        logic [7:0] ch;
        logic [9:0] idx;
        int r;
        chn = ($urandom_range(0, 99) < chan_bias) ? 2'd0 : 2'($urandom_range(0, 3));
        ch = ($urandom_range(0, 99) < digit_pct) ? digit_char() : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 50)
            idx = 10'($urandom_range(0, 40));
        else if (r < 80)
            idx = 10'($urandom_range(0, 1023));
        else
            idx = 10'($urandom_range(990, 1023));
        if ($urandom_range(0, 99) < 15)
            send(1'b1, chn, ch, 1'($urandom_range(0, 1)), idx);
        else
            send(1'b0, chn, ch, $urandom_range(0, 99) < eoc_pct, idx);
    endtask

    task settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // feeds give no result, so allow the slowest sample to finish
        repeat (20) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [33:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task write_coefs(input bit allow_bad);
        write_reg(REG_COEF0, rand_coef(allow_bad));
        write_reg(REG_COEF1, rand_coef(allow_bad));
        write_reg(REG_COEF2, rand_coef(allow_bad));
        write_reg(REG_COEF3, rand_coef(allow_bad));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at reset settings: digits, non-digits, reads at
        // the index extremes and a channel closed by its last character.
        send(1'b0, 2'd0, "1", 1'b0, 10'd0);
        send(1'b0, 2'd0, "2", 1'b0, 10'd0);
        send(1'b0, 2'd0, "a", 1'b0, 10'd0);
        send(1'b0, 2'd0, 8'hFF, 1'b0, 10'd0);
        send(1'b0, 2'd0, 8'h00, 1'b0, 10'd0);
        send(1'b0, 2'd0, "9", 1'b0, 10'd0);
        send(1'b0, 2'd0, "0", 1'b0, 10'd0);
        send(1'b1, 2'd0, 8'h00, 1'b0, 10'd0);
        send(1'b1, 2'd3, 8'hFF, 1'b1, 10'd1);
        send(1'b1, 2'd0, 8'h00, 1'b0, 10'd1023);
        send(1'b0, 2'd1, "5", 1'b0, 10'd0);
        send(1'b0, 2'd1, "7", 1'b0, 10'd0);
        send(1'b1, 2'd0, 8'h00, 1'b0, 10'd2);
        send(1'b0, 2'd2, "4", 1'b0, 10'd0);
        send(1'b0, 2'd3, "8", 1'b1, 10'd0);
        send(1'b0, 2'd3, "6", 1'b0, 10'd0);
        send(1'b1, 2'd0, 8'h00, 1'b0, 10'd3);
        settle();

        // Zero chunk length and coefficient extremes, including bad ones.
        write_reg(REG_CHUNK_LEN, 34'd0);
        write_reg(REG_COEF0, 34'd0);
        write_reg(REG_COEF1, 34'd8590000128);
        write_reg(REG_COEF2, {17'd65537, 17'd100});
        write_reg(REG_COEF3, 34'h3FFFFFFFF);
        repeat (150) send_random(0, 0, 75);
        settle();

        // Long chunks make values wrap past 32 bits.
        write_reg(REG_CHUNK_LEN, 34'd18);
        write_coefs(1'b0);
        calm = 1'b1;
        repeat (150) send_random(30, 0, 95);
        calm = 1'b0;
        settle();

        write_reg(REG_CHUNK_LEN, 34'd3);
        write_coefs(1'b1);
        repeat (150) send_random(0, 0, 70);
        settle();

        // Fill the sum memory from channel 0 until samples are dropped.
        write_reg(REG_CHUNK_LEN, 34'd1);
        write_reg(REG_COEF0, {17'd32768, 17'd65536});
        for (int i = 0; i < 1150; i++)
        begin
            if (i % 20 == 0)
                send(1'b1, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0,
                     10'($urandom_range(0, 1023)));
            else if (i % 16 == 0)
                send_random(0, 0, 50);
            else
                send(1'b0, 2'd0, digit_char(), 1'b0, 10'($urandom_range(0, 1023)));
        end
        send(1'b1, 2'd0, 8'h00, 1'b0, 10'd1023);
        send(1'b1, 2'd0, 8'h00, 1'b0, 10'd1022);
        settle();

        // Over-long chunks; more channels now end, some chunks closing early.
        write_reg(REG_CHUNK_LEN, 34'd31);
        write_coefs(1'b1);
        repeat (230) send_random(20, 3, 80);
        settle();

        $display("Sent %0d input transactions and checked %0d read results over",
                 items_sent, reads_checked);
        $display("six register settings, including a filled sum memory.");
        if (failures == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ===== sim.f =====
src/csgm_pkg.sv
src/csgm_mac.sv
src/channel_smooth_gain_mixer.sv
src/csgm_checker.sv
tb/sv/csgm_checker.sv
tb/sv/tb.sv
